@@ sv/ipde_pkg.sv @@
// ----------------------------------------------------------------------------
// ipde_pkg
// Shared types and constants for the infrared pulse-distance frame encoder.
// ----------------------------------------------------------------------------
package ipde_pkg;

	// width of the shift word that holds the command in flight
	localparam int WORD_BITS = 16;
	localparam int CMD_W     = 16;
	localparam int LEN_W     = 8;
	localparam int CNT_W     = 5;

	// gap after the stop pulse: periods of fixed length
	localparam logic [7:0]       GAP_PERIODS_MAX = 8'd130;
	localparam logic [LEN_W-1:0] GAP_PERIOD_LEN  = 8'd40;
	localparam logic [LEN_W-1:0] PULSE_LEN       = 8'd1;

	// repeat frames invert the low nibble of the stored command
	localparam logic [WORD_BITS-1:0] REPEAT_FLIP = WORD_BITS'(4'hF);

	// register reset values
	localparam logic [LEN_W-1:0] LEAD_TIME_RST     = 8'd13;
	localparam logic [LEN_W-1:0] ZERO_GAP_TIME_RST = 8'd4;
	localparam logic [LEN_W-1:0] ONE_GAP_TIME_RST  = 8'd8;
	localparam logic [CNT_W-1:0] BIT_COUNT_RST     = 5'd10;

	// item kinds
	typedef enum logic [1:0] {
		KIND_TICK   = 2'd0,
		KIND_SEND   = 2'd1,
		KIND_REPEAT = 2'd2,
		KIND_STOP   = 2'd3
	} kind_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_LEAD_TIME     = 2'd0,
		REG_ZERO_GAP_TIME = 2'd1,
		REG_ONE_GAP_TIME  = 2'd2,
		REG_BIT_COUNT     = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [LEN_W-1:0] lead_time;
		logic [LEN_W-1:0] zero_gap_time;
		logic [LEN_W-1:0] one_gap_time;
		logic [CNT_W-1:0] bit_count;
	} cfg_t;

	typedef struct packed {
		logic             carrier_on;
		logic [LEN_W-1:0] step_length;
		logic             busy;
	} res_t;

endpackage

@@ sv/ipde_cfg.sv @@
// ----------------------------------------------------------------------------
// ipde_cfg
// Configuration registers: step lengths and data bit count.
// ----------------------------------------------------------------------------
module ipde_cfg (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_index,
	input  logic [7:0]            cfg_wdata,
	output ipde_pkg::cfg_t        cfg
);
	import ipde_pkg::*;

	cfg_t cfg_q;

	// register write decode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lead_time     <= LEAD_TIME_RST;
			cfg_q.zero_gap_time <= ZERO_GAP_TIME_RST;
			cfg_q.one_gap_time  <= ONE_GAP_TIME_RST;
			cfg_q.bit_count     <= BIT_COUNT_RST;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_LEAD_TIME:     cfg_q.lead_time     <= cfg_wdata;
				REG_ZERO_GAP_TIME: cfg_q.zero_gap_time <= cfg_wdata;
				REG_ONE_GAP_TIME:  cfg_q.one_gap_time  <= cfg_wdata;
				REG_BIT_COUNT:     cfg_q.bit_count     <= cfg_wdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ sv/ipde_core.sv @@
// ----------------------------------------------------------------------------
// ipde_core
// Frame sequencer: holds frame state; one item per cycle with advance high.
// ----------------------------------------------------------------------------
module ipde_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           advance,
	input  logic [1:0]                     kind,
	input  logic [ipde_pkg::CMD_W-1:0]     command_value,
	input  ipde_pkg::cfg_t                 cfg,
	output ipde_pkg::res_t                 res
);
	import ipde_pkg::*;

	typedef enum logic [3:0] {
		PH_IDLE      = 4'd0,
		PH_LEADIN_A  = 4'd1,
		PH_LEADIN_B  = 4'd2,
		PH_START_A   = 4'd3,
		PH_START_B   = 4'd4,
		PH_BIT_A     = 4'd5,
		PH_BIT_B     = 4'd6,
		PH_LEADOUT_A = 4'd7,
		PH_LEADOUT_B = 4'd8,
		PH_STOP      = 4'd9,
		PH_WAIT      = 4'd10
	} phase_t;

	phase_t                 phase_q, phase_d;
	logic [WORD_BITS-1:0]   shift_q, shift_d;
	logic [CNT_W-1:0]       sent_q, sent_d;
	logic [7:0]             gap_q, gap_d;
	logic [WORD_BITS-1:0]   stored_q, stored_d;
	logic [LEN_W-1:0]       last_q, last_d;
	logic                   carrier;
	logic [31:0]            cmd_ext;
	logic [WORD_BITS-1:0]   cmd_w;

	// command truncated or zero-extended to the word width
	assign cmd_ext = 32'(command_value);
	assign cmd_w   = cmd_ext[WORD_BITS-1:0];

	// next state and result
	always_comb begin
		phase_d  = phase_q;
		shift_d  = shift_q;
		sent_d   = sent_q;
		gap_d    = gap_q;
		stored_d = stored_q;
		last_d   = last_q;
		carrier  = 1'b0;
		case (kind_t'(kind))
			KIND_TICK: begin
				unique case (phase_q)
					PH_LEADIN_A, PH_START_A, PH_BIT_A, PH_LEADOUT_A, PH_STOP: begin
						carrier = 1'b1;
						last_d  = PULSE_LEN;
						phase_d = phase_t'(phase_q + 4'd1);
					end
					PH_LEADIN_B, PH_LEADOUT_B: begin
						last_d  = cfg.lead_time;
						phase_d = phase_t'(phase_q + 4'd1);
					end
					PH_START_B: begin
						last_d  = cfg.zero_gap_time;
						phase_d = PH_BIT_A;
					end
					PH_BIT_B: begin
						last_d  = shift_q[0] ? cfg.one_gap_time : cfg.zero_gap_time;
						shift_d = shift_q >> 1;
						sent_d  = sent_q + 5'd1;
						// count wraps to zero as well as reaching the limit
						if (sent_d >= cfg.bit_count || sent_d == '0)
							phase_d = PH_LEADOUT_A;
						else
							phase_d = PH_BIT_A;
					end
					PH_WAIT: begin
						last_d = GAP_PERIOD_LEN;
						gap_d  = gap_q + 8'd1;
						if (gap_d >= GAP_PERIODS_MAX) begin
							sent_d  = '0;
							gap_d   = '0;
							phase_d = PH_IDLE;
						end
					end
					default: phase_d = PH_IDLE;
				endcase
			end
			KIND_SEND: begin
				stored_d = cmd_w;
				if (cmd_w != '0 && phase_q == PH_IDLE) begin
					shift_d = cmd_w;
					phase_d = PH_LEADIN_A;
				end
			end
			KIND_REPEAT: begin
				if (stored_q != '0 && phase_q == PH_IDLE) begin
					shift_d = stored_q ^ REPEAT_FLIP;
					phase_d = PH_LEADIN_A;
				end
			end
			default: stored_d = '0;
		endcase
		res.carrier_on  = carrier;
		res.step_length = last_d;
		res.busy        = (phase_d != PH_IDLE);
	end

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			shift_q  <= '0;
			sent_q   <= '0;
			gap_q    <= '0;
			stored_q <= '0;
			last_q   <= PULSE_LEN;
		end else if (advance) begin
			phase_q  <= phase_d;
			shift_q  <= shift_d;
			sent_q   <= sent_d;
			gap_q    <= gap_d;
			stored_q <= stored_d;
			last_q   <= last_d;
		end
	end

endmodule

@@ sv/ir_pulse_distance_frame_encoder.sv @@
// ----------------------------------------------------------------------------
// ir_pulse_distance_frame_encoder
// Infrared pulse-distance frame encoder: ticks step the frame, commands start it.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock cycle while out_ready lets the
// output drain, and returns exactly one result for each. A transaction sits
// in the input register, the frame sequencer works it out from there, and
// the result lands in the output register, which drives out_valid. The
// output register decouples the sides, so the input keeps accepting while
// a result waits; a stalled output backs up into the input register after
// one more transaction. Configuration is written through
// cfg_we/cfg_index/cfg_wdata and must only change while no transaction is
// in flight.
module ir_pulse_distance_frame_encoder (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  kind,
	input  logic [ipde_pkg::CMD_W-1:0]  command_value,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        carrier_on,
	output logic [ipde_pkg::LEN_W-1:0]  step_length,
	output logic                        busy_res,
	input  logic                        cfg_we,
	input  logic [1:0]                  cfg_index,
	input  logic [7:0]                  cfg_wdata
);
	import ipde_pkg::*;

	logic             valid_s1;
	logic [1:0]       kind_s1;
	logic [CMD_W-1:0] cmd_s1;
	logic             advance;
	cfg_t             cfg;
	res_t             res;
	res_t             res_q;
	logic             out_valid_q;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	ipde_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	ipde_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance),
		.kind          (kind_s1),
		.command_value (cmd_s1),
		.cfg           (cfg),
		.res           (res)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			kind_s1 <= kind;
			cmd_s1  <= command_value;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign carrier_on  = res_q.carrier_on;
	assign step_length = res_q.step_length;
	assign busy_res    = res_q.busy;

endmodule

@@ sv/ipde_checker.sv @@
// ----------------------------------------------------------------------------
// ipde_checker
// Port-level checks on the encoder result channel.
// ----------------------------------------------------------------------------
module ipde_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic       carrier_on,
	input logic [7:0] step_length,
	input logic       busy_res
);
	import ipde_pkg::*;

	// a stalled result stays valid
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its length
	a_len_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(step_length))
		else $error("step length changed while stalled");

	// carrier steps only happen inside a frame
	a_carrier_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && carrier_on |-> busy_res)
		else $error("carrier on outside a frame");

	// every carrier step is a single-tick pulse
	a_pulse_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && carrier_on |-> step_length == PULSE_LEN)
		else $error("carrier pulse with wrong length");

endmodule

bind ir_pulse_distance_frame_encoder ipde_checker u_ipde_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.carrier_on  (carrier_on),
	.step_length (step_length),
	.busy_res    (busy_res)
);
